[hdl/ddd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_pkg: shared types and constants of the dense shortest-distance engine
// Holds the word formats of both channels, the node table entry format, the
// sequencer states and the operation and status codes.
// ----------------------------------------------------------------------------
package ddd_pkg;

  localparam int MAX_NODES   = 64;
  localparam int WEIGHT_BITS = 16;

  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int COUNT_W     = $clog2(MAX_NODES + 1);
  localparam int WADDR_W     = 2 * NODE_BITS;
  localparam int DIST_W      = 22;
  localparam int SUM_W       = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

  // Field widths of the channel words.
  localparam int CFG_W       = 7;
  localparam int NODE_FW     = 6;
  localparam int WEIGHT_FW   = 16;
  localparam int STATUS_W    = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNREACH = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  typedef struct packed {
    logic                 operation;
    logic [NODE_FW-1:0]   from_node;
    logic [NODE_FW-1:0]   to_node;
    logic [WEIGHT_FW-1:0] edge_weight;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0]   distance;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // One entry of the per-query node table.
  typedef struct packed {
    logic              settled;
    logic              reach;
    logic [DIST_W-1:0] path_len;
  } node_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_RELAX,
    ST_READ,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

[hdl/ddd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ddd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/ddd_relax.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_relax: edge relaxation unit
// Updates one node table entry through the edge from the node settled in
// this round, and flags whether the result is a candidate for the next one.
// ----------------------------------------------------------------------------
module ddd_relax (
  input  wire ddd_pkg::node_entry_t             entry,
  input  wire logic [ddd_pkg::WEIGHT_BITS-1:0]  weight,
  input  wire logic                             is_best,
  input  wire logic [ddd_pkg::DIST_W-1:0]       best_dist,
  output      ddd_pkg::node_entry_t             entry_next,
  output      logic                             candidate
);
  import ddd_pkg::*;

  logic              settled_now;
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] cand;

  always_comb begin
    settled_now = entry.settled | is_best;
    sum         = SUM_W'(best_dist) + SUM_W'(weight);
    cand        = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

    entry_next         = entry;
    entry_next.settled = settled_now;
    if (!settled_now && (weight != '0) && (!entry.reach || (cand < entry.path_len))) begin
      entry_next.reach    = 1'b1;
      entry_next.path_len = cand;
    end
    candidate = !entry_next.settled && entry_next.reach;
  end

endmodule
`default_nettype wire

[hdl/dense_dijkstra_distance.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dense_dijkstra_distance: shortest distance over a dense weight matrix
// A write word stores one edge weight in the 64 x 64 matrix. A query word
// runs Dijkstra from from_node over the first n nodes (n = node_count, 0
// read as 1, capped at 64) and returns the distance to to_node with a
// status. A query first initializes the node table, then runs at most n-1
// rounds (fewer if the reachable set runs out), then reads the target.
// The node table is read one node per cycle; each round relaxes every node
// and picks the next node to settle in that same pass. After reset the
// weight matrix is cleared one entry per cycle, which keeps the input
// stalled until every entry is cleared; configuration writes are taken
// throughout. An out-of-range query skips the node table and goes straight
// to the result.
// ----------------------------------------------------------------------------
module dense_dijkstra_distance (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [ddd_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire ddd_pkg::in_word_t         in_word,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      ddd_pkg::out_word_t        out_word
);
  import ddd_pkg::*;

  state_t             state, state_next;
  logic [CFG_W-1:0]   node_count;
  logic [WADDR_W-1:0] clear_addr, clear_addr_next;
  logic [NODE_BITS-1:0] src, src_next, dst, dst_next;
  logic [COUNT_W-1:0] n_eff, n_eff_next;
  logic [COUNT_W-1:0] issue_idx, issue_idx_next;
  logic [COUNT_W-1:0] round, round_next;
  logic               stage_valid, stage_valid_next;
  logic [NODE_BITS-1:0] stage_idx, stage_idx_next;
  logic [NODE_BITS-1:0] best, best_next, next_best, next_best_next;
  logic [DIST_W-1:0]  best_dist, best_dist_next, next_best_dist, next_best_dist_next;
  logic               next_found, next_found_next;
  logic               range_fail, range_fail_next;
  logic               out_load;
  out_word_t          out_word_next;

  logic [COUNT_W-1:0] n_calc;
  logic               in_accept, issuing, take_cand, found_now, round_end;
  logic [NODE_BITS-1:0] nb_now;
  logic [DIST_W-1:0]  nbd_now;

  // Weight matrix port signals
  logic                   w_we;
  logic [WADDR_W-1:0]     w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;

  // Node table port signals
  logic                 t_we;
  logic [NODE_BITS-1:0] t_waddr, t_raddr;
  node_entry_t          t_wdata, t_rdata, relax_entry;
  logic                 relax_cand;

  ddd_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_NODES * MAX_NODES)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  ddd_ram #(
    .WIDTH ($bits(node_entry_t)),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  ddd_relax u_relax (
    .entry      (t_rdata),
    .weight     (w_rdata),
    .is_best    (stage_idx == best),
    .best_dist  (best_dist),
    .entry_next (relax_entry),
    .candidate  (relax_cand)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CFG_W'(MAX_NODES);
    end else if (cfg_write) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clear_addr  <= '0;
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clear_addr  <= clear_addr_next;
      stage_valid <= stage_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src            <= src_next;
    dst            <= dst_next;
    n_eff          <= n_eff_next;
    issue_idx      <= issue_idx_next;
    round          <= round_next;
    stage_idx      <= stage_idx_next;
    best           <= best_next;
    best_dist      <= best_dist_next;
    next_best      <= next_best_next;
    next_best_dist <= next_best_dist_next;
    next_found     <= next_found_next;
    range_fail     <= range_fail_next;
    if (out_load) begin
      out_word <= out_word_next;
    end
  end

  always_comb begin
    if (node_count == '0) begin
      n_calc = COUNT_W'(1);
    end else if (32'(node_count) > 32'(MAX_NODES)) begin
      n_calc = COUNT_W'(MAX_NODES);
    end else begin
      n_calc = COUNT_W'(node_count);
    end
  end

  always_comb begin
    state_next          = state;
    clear_addr_next     = clear_addr;
    src_next            = src;
    dst_next            = dst;
    n_eff_next          = n_eff;
    issue_idx_next      = issue_idx;
    round_next          = round;
    stage_idx_next      = issue_idx[NODE_BITS-1:0];
    best_next           = best;
    best_dist_next      = best_dist;
    next_best_next      = next_best;
    next_best_dist_next = next_best_dist;
    next_found_next     = next_found;
    range_fail_next     = range_fail;
    out_load            = 1'b0;
    out_word_next       = '0;

    in_stall  = (state != ST_IDLE);
    in_accept = in_valid && (state == ST_IDLE);
    issuing   = (state == ST_RELAX) && (issue_idx < n_eff);
    stage_valid_next = issuing;

    w_we    = 1'b0;
    w_waddr = {in_word.from_node[NODE_BITS-1:0], in_word.to_node[NODE_BITS-1:0]};
    w_wdata = WEIGHT_BITS'(in_word.edge_weight);
    w_raddr = {best, issue_idx[NODE_BITS-1:0]};

    t_we    = 1'b0;
    t_waddr = issue_idx[NODE_BITS-1:0];
    t_wdata = '0;
    t_raddr = (state == ST_RELAX) ? issue_idx[NODE_BITS-1:0] : dst;

    // The next node to settle is picked on the fly from the relaxed values;
    // on equal distances the later node wins.
    take_cand = stage_valid && relax_cand &&
                (!next_found || (relax_entry.path_len <= next_best_dist));
    found_now = next_found || take_cand;
    nb_now    = take_cand ? stage_idx : next_best;
    nbd_now   = take_cand ? relax_entry.path_len : next_best_dist;
    round_end = stage_valid && (COUNT_W'(stage_idx) == (n_eff - COUNT_W'(1)));

    unique case (state)
      ST_CLEAR: begin
        w_we            = 1'b1;
        w_waddr         = clear_addr;
        w_wdata         = '0;
        clear_addr_next = clear_addr + WADDR_W'(1);
        if (clear_addr == {WADDR_W{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_word.operation == OP_WRITE) begin
            w_we = (32'(in_word.from_node) < 32'(MAX_NODES)) &&
                   (32'(in_word.to_node) < 32'(MAX_NODES));
          end else begin
            src_next        = in_word.from_node[NODE_BITS-1:0];
            dst_next        = in_word.to_node[NODE_BITS-1:0];
            n_eff_next      = n_calc;
            issue_idx_next  = '0;
            range_fail_next = (32'(in_word.from_node) >= 32'(n_calc)) ||
                              (32'(in_word.to_node) >= 32'(n_calc));
            state_next      = range_fail_next ? ST_RESULT : ST_INIT;
          end
        end
      end
      ST_INIT: begin
        t_we          = 1'b1;
        t_wdata.reach = (issue_idx[NODE_BITS-1:0] == src);
        if (issue_idx == (n_eff - COUNT_W'(1))) begin
          issue_idx_next  = '0;
          round_next      = '0;
          best_next       = src;
          best_dist_next  = '0;
          next_found_next = 1'b0;
          state_next      = (n_eff == COUNT_W'(1)) ? ST_READ : ST_RELAX;
        end else begin
          issue_idx_next = issue_idx + COUNT_W'(1);
        end
      end
      ST_RELAX: begin
        if (issuing) begin
          issue_idx_next = issue_idx + COUNT_W'(1);
        end
        t_we    = stage_valid;
        t_waddr = stage_idx;
        t_wdata = relax_entry;
        next_found_next     = found_now;
        next_best_next      = nb_now;
        next_best_dist_next = nbd_now;
        if (round_end) begin
          if (!found_now || (({1'b0, round} + (COUNT_W + 1)'(2)) == {1'b0, n_eff})) begin
            state_next = ST_READ;
          end else begin
            best_next       = nb_now;
            best_dist_next  = nbd_now;
            round_next      = round + COUNT_W'(1);
            issue_idx_next  = '0;
            next_found_next = 1'b0;
          end
        end
      end
      ST_READ: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (range_fail) begin
          out_word_next.status = STATUS_RANGE;
        end else if (t_rdata.reach) begin
          out_word_next.distance = t_rdata.path_len;
          out_word_next.status   = STATUS_OK;
        end else begin
          out_word_next.status = STATUS_UNREACH;
        end
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/ddd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_checker: port-level checks of the shortest-distance engine
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module ddd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire ddd_pkg::in_word_t         in_word,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire ddd_pkg::out_word_t        out_word
);
  import ddd_pkg::*;

  // No result word may be pending right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word visible after reset");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // Only a reachable target carries a distance.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status != STATUS_OK) |-> (out_word.distance == '0))
    else $error("distance given with a failing status");

  // A query occupies the engine for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_word.operation == OP_QUERY) |=> in_stall)
    else $error("input taken right after a query");

  // After a weight write the engine takes input again in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_word.operation == OP_WRITE) |=> !in_stall)
    else $error("engine stalled after a weight write");

endmodule

bind dense_dijkstra_distance ddd_checker u_ddd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

[tb/dense_dijkstra_distance_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dense_dijkstra_distance_tb: self-checking bench for the distance engine
// A short table of directed words runs first. It covers the empty matrix
// after reset, source equal to target, out-of-range nodes, node counts of
// zero, one and above the maximum, heavy weights and equal-distance ties.
// Random phases follow on small graphs, with and without idle cycles on
// either side. Every query result is compared with the expected word given
// in its table row or else with a local shortest-path model that mirrors the weight matrix and the node count.
// ----------------------------------------------------------------------------
module dense_dijkstra_distance_tb;
  import ddd_pkg::*;

  typedef enum logic {ROW_WORD, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [CFG_W-1:0] count_value;
    in_word_t        word;
    logic            typed;
    out_word_t       result;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_word_t         in_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;

  logic [WEIGHT_FW-1:0] weight_copy [MAX_NODES][MAX_NODES];
  logic [CFG_W-1:0]     node_count_copy = 7'd64;
  out_word_t            pending_distances [$];
  stim_row_t            directed_rows [$];
  int                   mismatch_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;

  dense_dijkstra_distance dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int active_nodes();
    if (node_count_copy == 0) return 1;
    if (node_count_copy > MAX_NODES) return MAX_NODES;
    return int'(node_count_copy);
  endfunction

  function automatic out_word_t shortest_distance(logic [NODE_FW-1:0] src,
                                                  logic [NODE_FW-1:0] dst);
    int                n;
    int                best;
    bit                found;
    logic [DIST_W-1:0] bestd;
    logic [DIST_W-1:0] cand;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] tent_len [MAX_NODES];
    bit                settled [MAX_NODES];
    bit                reach [MAX_NODES];
    out_word_t         res;
    n = active_nodes();
    res = '0;
    if (src >= n || dst >= n) begin
      res.status = STATUS_RANGE;
      return res;
    end
    for (int v = 0; v < n; v++) begin
      tent_len[v] = '0;
      settled[v] = 1'b0;
      reach[v] = 1'b0;
    end
    reach[src] = 1'b1;
    for (int r = 0; r + 1 < n; r++) begin
      found = 1'b0;
      best = 0;
      bestd = '0;
      // The "<=" lets a later node win a tie on distance.
      for (int v = 0; v < n; v++) begin
        if (!settled[v] && reach[v] && (!found || tent_len[v] <= bestd)) begin
          found = 1'b1;
          best = v;
          bestd = tent_len[v];
        end
      end
      if (!found) break;
      settled[best] = 1'b1;
      for (int v = 0; v < n; v++) begin
        if (!settled[v] && weight_copy[best][v] != '0) begin
          sum = {1'b0, bestd} + (DIST_W + 1)'(weight_copy[best][v]);
          cand = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
          if (!reach[v] || cand < tent_len[v]) begin
            tent_len[v] = cand;
            reach[v] = 1'b1;
          end
        end
      end
    end
    if (reach[dst]) res.distance = tent_len[dst];
    else res.status = STATUS_UNREACH;
    return res;
  endfunction

  function automatic stim_row_t word_row(logic op, int from_n, int to_n, int weight);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.word.operation = op;
    row.word.from_node = NODE_FW'(from_n);
    row.word.to_node = NODE_FW'(to_n);
    row.word.edge_weight = WEIGHT_FW'(weight);
    return row;
  endfunction

  function automatic stim_row_t checked_row(int from_n, int to_n,
                                            logic [STATUS_W-1:0] status, int dist_value);
    stim_row_t row;
    row = word_row(OP_QUERY, from_n, to_n, 0);
    row.typed = 1'b1;
    row.result.status = status;
    row.result.distance = DIST_W'(dist_value);
    return row;
  endfunction

  function automatic stim_row_t count_row(int value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_COUNT;
    row.count_value = CFG_W'(value);
    return row;
  endfunction

  function automatic void add_row(stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // Mostly well-formed words inside the active node range; some words
  // use any node index and so hit the range check or unused matrix rows.
  function automatic in_word_t random_word();
    int       n;
    in_word_t w;
    n = active_nodes();
    w.operation = ($urandom_range(99) < 40) ? OP_QUERY : OP_WRITE;
    if ($urandom_range(99) < 15) begin
      w.from_node = NODE_FW'($urandom);
      w.to_node = NODE_FW'($urandom);
    end else begin
      w.from_node = NODE_FW'($urandom_range(n - 1));
      w.to_node = NODE_FW'($urandom_range(n - 1));
    end
    case ($urandom_range(7))
      0: w.edge_weight = '0;
      1: w.edge_weight = '1;
      2, 3, 4: w.edge_weight = WEIGHT_FW'($urandom_range(16, 1));
      default: w.edge_weight = WEIGHT_FW'($urandom);
    endcase
    return w;
  endfunction

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(in_word_t w, logic typed, out_word_t typed_res);
    out_word_t expected;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    if (w.operation == OP_QUERY) begin
      expected = typed ? typed_res : shortest_distance(w.from_node, w.to_node);
      pending_distances = {pending_distances, expected};
    end else begin
      weight_copy[w.from_node][w.to_node] = w.edge_weight;
    end
  endtask

  // A write word gives no result, so the task waits past the last one
  // before the node count changes.
  task automatic write_node_count(logic [CFG_W-1:0] value);
    wait_drain();
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    node_count_copy = value;
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_distances.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, expected none, actual distance %0d status %0d",
                 $time, out_word.distance, out_word.status);
      end else begin
        if (out_word.distance !== pending_distances[0].distance) begin
          mismatch_count++;
          $display("%0t: distance mismatch, expected %0d actual %0d",
                   $time, pending_distances[0].distance, out_word.distance);
        end
        if (out_word.status !== pending_distances[0].status) begin
          mismatch_count++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, pending_distances[0].status, out_word.status);
        end
        void'(pending_distances.pop_front());
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    foreach (weight_copy[i, j]) weight_copy[i][j] = '0;

    // Empty matrix after reset, then a few heavy edges and a tie on distance.
    add_row(checked_row(0, 63, STATUS_UNREACH, 0));
    add_row(checked_row(63, 63, STATUS_OK, 0));
    add_row(word_row(OP_WRITE, 0, 1, 65535));
    add_row(word_row(OP_WRITE, 1, 63, 65535));
    add_row(word_row(OP_WRITE, 0, 2, 1));
    add_row(word_row(OP_WRITE, 2, 63, 0));
    add_row(word_row(OP_QUERY, 0, 63, 0));
    add_row(word_row(OP_WRITE, 2, 1, 1));
    add_row(word_row(OP_WRITE, 0, 3, 2));
    add_row(word_row(OP_QUERY, 0, 63, 0));
    add_row(count_row(4));
    add_row(word_row(OP_QUERY, 0, 1, 0));
    add_row(word_row(OP_QUERY, 0, 3, 0));
    add_row(word_row(OP_QUERY, 3, 0, 0));
    add_row(checked_row(0, 4, STATUS_RANGE, 0));
    add_row(checked_row(63, 0, STATUS_RANGE, 0));
    // A node count of zero behaves as one node.
    add_row(count_row(0));
    add_row(checked_row(0, 0, STATUS_OK, 0));
    add_row(checked_row(1, 0, STATUS_RANGE, 0));
    add_row(count_row(1));
    add_row(checked_row(0, 0, STATUS_OK, 0));
    // Counts above the matrix size are capped.
    add_row(count_row(127));
    add_row(word_row(OP_WRITE, 63, 0, 65535));
    add_row(word_row(OP_QUERY, 63, 1, 0));
    add_row(count_row(64));
    add_row(word_row(OP_WRITE, 0, 1, 0));
    add_row(word_row(OP_QUERY, 63, 1, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_COUNT)
        write_node_count(directed_rows[i].count_value);
      else
        send_word(directed_rows[i].word, directed_rows[i].typed,
                  directed_rows[i].result);
    end

    for (int phase = 0; phase < 4; phase++) begin
      write_node_count((phase == 3) ? CFG_W'($urandom_range(24, 1))
                                    : CFG_W'($urandom_range(12, 2)));
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      repeat (30) begin
        if ($urandom_range(29) == 0) wait_drain();
        send_word(random_word(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
